@@ rtl/core/lav_pkg.sv @@
// ============================================================================
// lav_pkg - shared types and constants of the look-at view matrix core
// Field widths of the stream words and the side record that travels with
// each word down the pipeline.
// ============================================================================
package lav_pkg;

    // Fixed field widths of the stream words
    localparam int POS_W = 32;
    localparam int DIR_W = 16;
    localparam int IN_W  = 3 * POS_W + 3 * DIR_W;
    localparam int OUT_W = 8 * DIR_W + 3 * POS_W;

    // Width of squared lengths and squared components fed to the normalizers
    localparam int SQ_W = 64;

    // Pose data carried alongside the normalizer lanes
    typedef struct packed {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
        logic signed [DIR_W-1:0] dx;
        logic signed [DIR_W-1:0] dy;
        logic signed [DIR_W-1:0] dz;
        logic                    degen;
        logic signed [POS_W-1:0] tf;
    } side_t;

endpackage

@@ rtl/core/lav_norm_lane.sv @@
// ============================================================================
// lav_norm_lane - pipelined rounded unit component
// Finds n = round(|v| * 2^F / sqrt(s)), at most 2^F, one result bit per
// stage by incremental squaring, and applies the sign of v at the end.
// ============================================================================
module lav_norm_lane #(
    parameter int DIR_FRAC_BITS = 14
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic [lav_pkg::SQ_W-1:0]           vsq,   // v squared
    input  logic [lav_pkg::SQ_W-1:0]           sqr,   // squared vector length
    input  logic                               neg,   // sign of v
    output logic signed [DIR_FRAC_BITS+1:0]    comp
);

    localparam int F  = DIR_FRAC_BITS;
    localparam int SW = lav_pkg::SQ_W;
    localparam int W  = 2 * F + SW + 4;

    // Per-stage state: n, P = (2n-1)^2 s, Q = (2n-1) s, target, s, sign
    logic [F:0]            n_reg   [0:F];
    logic signed [W-1:0]   p_reg   [0:F];
    logic signed [W-1:0]   q_reg   [0:F];
    logic signed [W-1:0]   t_reg   [0:F];
    logic [SW-1:0]         s_reg   [0:F];
    logic                  neg_reg [0:F];

    for (genvar g = 0; g <= F; g++) begin : g_stage
        localparam int B = F - g;

        logic [F:0]          n_in;
        logic signed [W-1:0] p_in;
        logic signed [W-1:0] q_in;
        logic signed [W-1:0] t_in;
        logic [SW-1:0]       s_in;
        logic                neg_in;
        logic signed [W-1:0] s_w;
        logic signed [W-1:0] trial;
        logic                take;

        if (g == 0) begin : g_first
            // Start from n = 0: P = s, Q = -s, target 4 v^2 2^(2F)
            assign n_in   = '0;
            assign s_in   = sqr;
            assign p_in   = $signed({{(W-SW){1'b0}}, sqr});
            assign q_in   = -$signed({{(W-SW){1'b0}}, sqr});
            assign t_in   = $signed({{(W-SW){1'b0}}, vsq}) <<< (2 * F + 2);
            assign neg_in = neg;
        end else begin : g_next
            assign n_in   = n_reg[g-1];
            assign s_in   = s_reg[g-1];
            assign p_in   = p_reg[g-1];
            assign q_in   = q_reg[g-1];
            assign t_in   = t_reg[g-1];
            assign neg_in = neg_reg[g-1];
        end

        // Try setting bit B: (2n-1+2^(B+1))^2 s against the target
        always_comb
        begin
            s_w   = $signed({{(W-SW){1'b0}}, s_in});
            trial = p_in + (q_in <<< (B + 2)) + (s_w <<< (2 * B + 2));
            take  = (trial <= t_in) && ((B == F) || !n_in[F]);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[g]   <= take ? (n_in | ((F+1)'(1) << B)) : n_in;
                p_reg[g]   <= take ? trial : p_in;
                q_reg[g]   <= take ? (q_in + (s_w <<< (B + 1))) : q_in;
                t_reg[g]   <= t_in;
                s_reg[g]   <= s_in;
                neg_reg[g] <= neg_in;
            end
        end
    end

    // Apply the sign
    assign comp = neg_reg[F] ? -$signed({1'b0, n_reg[F]}) : $signed({1'b0, n_reg[F]});

endmodule

@@ rtl/core/look_at_view_matrix_core.sv @@
// ============================================================================
// look_at_view_matrix_core - look-at camera view transform
// Turns a camera position and unit look direction into right, up and
// forward axes plus the three saturated translation terms of the view matrix.
// ============================================================================
//
//  channel  | direction | contents
//  ---------+-----------+------------------------------------------------
//  s_t*     | in        | pos_x, pos_y, pos_z (Q16.16), look_x/y/z (Q2.14)
//  m_t*     | out       | right, up, fwd axes, trans terms; tuser degenerate
//
//  One word is accepted per cycle while the pipeline advances. The depth is
//  set by the rounding search that resolves one result bit per stage. rst_n
//  clears only the valid bits. When the output word is not taken, the whole
//  pipeline holds and s_tready drops; bubbles pass through.
//
module look_at_view_matrix_core #(
    parameter int DIR_FRAC_BITS = 14
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // pos_x, pos_y, pos_z, look_x, look_y, look_z
    input  logic [lav_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // right_x, right_z, up_x, up_y, up_z, fwd_x, fwd_y, fwd_z,
    // trans_right, trans_up, trans_fwd
    output logic [lav_pkg::OUT_W-1:0] m_tdata,
    // degenerate
    output logic [0:0]                m_tuser
);

    localparam int F   = DIR_FRAC_BITS;
    localparam int CW  = F + 2;
    localparam int PW  = CW + lav_pkg::POS_W;
    localparam int TSW = (F + 36 > 50) ? F + 36 : 50;
    localparam int NST = F + 8;
    localparam int SW  = lav_pkg::SQ_W;

    localparam logic signed [TSW+1:0] RND_HALF = (TSW+2)'(1) <<< (F - 1);
    localparam logic signed [TSW+1:0] SAT_MAX  = (TSW+2)'(32'h7fff_ffff);
    localparam logic signed [TSW+1:0] SAT_MIN  = -(TSW+2)'(33'h0_8000_0000);

    // Negate, round at F fraction bits with ties up, saturate to 32 bits
    function automatic logic signed [31:0] finish_trans(input logic signed [TSW-1:0] t);
        logic signed [TSW+1:0] u;
        logic signed [TSW+1:0] r;
        u = RND_HALF - (TSW+2)'(t);
        r = u >>> F;
        if (r > SAT_MAX)
            return 32'sh7fff_ffff;
        else if (r < SAT_MIN)
            return 32'sh8000_0000;
        else
            return 32'(r);
    endfunction

    logic             adv;
    logic [NST-1:0]   vld_reg;

    // Advance the whole pipeline unless the output word is stuck
    assign adv      = !vld_reg[NST-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
    end

    // Stage A: capture the input word
    lav_pkg::side_t a_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_side_reg.px    <= s_tdata[31:0];
            a_side_reg.py    <= s_tdata[63:32];
            a_side_reg.pz    <= s_tdata[95:64];
            a_side_reg.dx    <= s_tdata[111:96];
            a_side_reg.dy    <= s_tdata[127:112];
            a_side_reg.dz    <= s_tdata[143:128];
            a_side_reg.degen <= (s_tdata[111:96] == '0) && (s_tdata[143:128] == '0);
            a_side_reg.tf    <= '0;
        end
    end

    // Stage B: direction products and forward dot products
    lav_pkg::side_t     b_side_reg;
    logic signed [31:0] b_dxx_reg, b_dyy_reg, b_dzz_reg, b_dydx_reg, b_dydz_reg;
    logic signed [47:0] b_tx_reg, b_ty_reg, b_tz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_side_reg <= a_side_reg;
            b_dxx_reg  <= $signed(a_side_reg.dx) * $signed(a_side_reg.dx);
            b_dyy_reg  <= $signed(a_side_reg.dy) * $signed(a_side_reg.dy);
            b_dzz_reg  <= $signed(a_side_reg.dz) * $signed(a_side_reg.dz);
            b_dydx_reg <= $signed(a_side_reg.dy) * $signed(a_side_reg.dx);
            b_dydz_reg <= $signed(a_side_reg.dy) * $signed(a_side_reg.dz);
            b_tx_reg   <= $signed(a_side_reg.dx) * $signed(a_side_reg.px);
            b_ty_reg   <= $signed(a_side_reg.dy) * $signed(a_side_reg.py);
            b_tz_reg   <= $signed(a_side_reg.dz) * $signed(a_side_reg.pz);
        end
    end

    // Stage C: squared lengths, look x right, forward sum
    lav_pkg::side_t      c_side_reg;
    logic [31:0]         c_sr_reg, c_l_reg, c_dxx_reg, c_dzz_reg;
    logic signed [31:0]  c_cx_reg, c_cz_reg;
    logic signed [TSW-1:0] c_tf_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_side_reg <= b_side_reg;
            c_sr_reg   <= 32'(b_dxx_reg) + 32'(b_dzz_reg);
            c_l_reg    <= 32'(b_dxx_reg) + 32'(b_dzz_reg) + 32'(b_dyy_reg);
            c_dxx_reg  <= 32'(b_dxx_reg);
            c_dzz_reg  <= 32'(b_dzz_reg);
            c_cx_reg   <= -b_dydx_reg;
            c_cz_reg   <= -b_dydz_reg;
            c_tf_reg   <= TSW'(b_tx_reg) + TSW'(b_ty_reg) + TSW'(b_tz_reg);
        end
    end

    // Fold the finished forward translation into the pose record
    lav_pkg::side_t c_side_fin;

    always_comb
    begin
        c_side_fin    = c_side_reg;
        c_side_fin.tf = finish_trans(c_tf_reg);
    end

    // Stage D: squares for the normalizers, finish the forward translation
    lav_pkg::side_t d_side_reg;
    logic [SW-1:0]  d_sr_reg, d_su_reg;
    logic [SW-1:0]  d_vrx_reg, d_vrz_reg, d_vux_reg, d_vuy_reg, d_vuz_reg;
    logic           d_nrx_reg, d_nrz_reg, d_nux_reg, d_nuz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_side_reg    <= c_side_fin;
            d_sr_reg      <= SW'(c_sr_reg);
            d_su_reg      <= c_sr_reg * c_l_reg;
            d_vrx_reg     <= SW'(c_dzz_reg);
            d_vrz_reg     <= SW'(c_dxx_reg);
            d_vux_reg     <= c_cx_reg * c_cx_reg;
            d_vuy_reg     <= c_sr_reg * c_sr_reg;
            d_vuz_reg     <= c_cz_reg * c_cz_reg;
            d_nrx_reg     <= c_side_reg.dz[15];
            d_nrz_reg     <= !c_side_reg.dx[15] && (c_side_reg.dx != '0);
            d_nux_reg     <= c_cx_reg[31];
            d_nuz_reg     <= c_cz_reg[31];
        end
    end

    // Normalizer lanes
    logic signed [CW-1:0] rx_w, rz_w, ux_w, uy_w, uz_w;

    lav_norm_lane #(.DIR_FRAC_BITS(F)) u_rx (
        .clk(clk), .en(adv), .vsq(d_vrx_reg), .sqr(d_sr_reg), .neg(d_nrx_reg), .comp(rx_w)
    );
    lav_norm_lane #(.DIR_FRAC_BITS(F)) u_rz (
        .clk(clk), .en(adv), .vsq(d_vrz_reg), .sqr(d_sr_reg), .neg(d_nrz_reg), .comp(rz_w)
    );
    lav_norm_lane #(.DIR_FRAC_BITS(F)) u_ux (
        .clk(clk), .en(adv), .vsq(d_vux_reg), .sqr(d_su_reg), .neg(d_nux_reg), .comp(ux_w)
    );
    lav_norm_lane #(.DIR_FRAC_BITS(F)) u_uy (
        .clk(clk), .en(adv), .vsq(d_vuy_reg), .sqr(d_su_reg), .neg(1'b0), .comp(uy_w)
    );
    lav_norm_lane #(.DIR_FRAC_BITS(F)) u_uz (
        .clk(clk), .en(adv), .vsq(d_vuz_reg), .sqr(d_su_reg), .neg(d_nuz_reg), .comp(uz_w)
    );

    // Delay the pose alongside the lanes
    lav_pkg::side_t l_side_reg [0:F];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l_side_reg[0] <= d_side_reg;
            for (int i = 1; i <= F; i++)
                l_side_reg[i] <= l_side_reg[i-1];
        end
    end

    // Stage E: zero degenerate axes, axis times position products
    lav_pkg::side_t       e_side_reg;
    logic signed [CW-1:0] rx_m, rz_m, ux_m, uy_m, uz_m;
    logic signed [15:0]   e_rx_reg, e_rz_reg, e_ux_reg, e_uy_reg, e_uz_reg;
    logic signed [PW-1:0] e_prx_reg, e_prz_reg, e_pux_reg, e_puy_reg, e_puz_reg;

    always_comb
    begin
        rx_m = l_side_reg[F].degen ? '0 : rx_w;
        rz_m = l_side_reg[F].degen ? '0 : rz_w;
        ux_m = l_side_reg[F].degen ? '0 : ux_w;
        uy_m = l_side_reg[F].degen ? '0 : uy_w;
        uz_m = l_side_reg[F].degen ? '0 : uz_w;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_side_reg <= l_side_reg[F];
            e_rx_reg   <= 16'(rx_m);
            e_rz_reg   <= 16'(rz_m);
            e_ux_reg   <= 16'(ux_m);
            e_uy_reg   <= 16'(uy_m);
            e_uz_reg   <= 16'(uz_m);
            e_prx_reg  <= rx_m * $signed(l_side_reg[F].px);
            e_prz_reg  <= rz_m * $signed(l_side_reg[F].pz);
            e_pux_reg  <= ux_m * $signed(l_side_reg[F].px);
            e_puy_reg  <= uy_m * $signed(l_side_reg[F].py);
            e_puz_reg  <= uz_m * $signed(l_side_reg[F].pz);
        end
    end

    // Stage F: dot product sums
    lav_pkg::side_t        f_side_reg;
    logic signed [15:0]    f_rx_reg, f_rz_reg, f_ux_reg, f_uy_reg, f_uz_reg;
    logic signed [TSW-1:0] f_tr_reg, f_tu_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_side_reg <= e_side_reg;
            f_rx_reg   <= e_rx_reg;
            f_rz_reg   <= e_rz_reg;
            f_ux_reg   <= e_ux_reg;
            f_uy_reg   <= e_uy_reg;
            f_uz_reg   <= e_uz_reg;
            f_tr_reg   <= TSW'(e_prx_reg) + TSW'(e_prz_reg);
            f_tu_reg   <= TSW'(e_pux_reg) + TSW'(e_puy_reg) + TSW'(e_puz_reg);
        end
    end

    // Stage G: finish translations into the output word
    lav_pkg::side_t     g_side_reg;
    logic signed [15:0] g_rx_reg, g_rz_reg, g_ux_reg, g_uy_reg, g_uz_reg;
    logic signed [31:0] g_tr_reg, g_tu_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_side_reg <= f_side_reg;
            g_rx_reg   <= f_rx_reg;
            g_rz_reg   <= f_rz_reg;
            g_ux_reg   <= f_ux_reg;
            g_uy_reg   <= f_uy_reg;
            g_uz_reg   <= f_uz_reg;
            g_tr_reg   <= finish_trans(f_tr_reg);
            g_tu_reg   <= finish_trans(f_tu_reg);
        end
    end

    assign m_tdata = {g_side_reg.tf, g_tu_reg, g_tr_reg,
                      g_side_reg.dz, g_side_reg.dy, g_side_reg.dx,
                      g_uz_reg, g_uy_reg, g_ux_reg, g_rz_reg, g_rx_reg};
    assign m_tuser = g_side_reg.degen;

endmodule

@@ tb/sv/tb_top.sv @@
// ============================================================================
// tb_top - self-checking testbench of the look-at view matrix core
// Drives camera poses through the slave stream and checks every view word
// that leaves the master stream against a bit-exact predictor.  Both sides
// idle and stall at random.
// ============================================================================
module tb_top;

    localparam int DIR_F    = 14;
    localparam int N_RANDOM = 1430;

    // One camera pose as it travels on s_tdata
    typedef struct packed {
        logic signed [lav_pkg::DIR_W-1:0] lz;
        logic signed [lav_pkg::DIR_W-1:0] ly;
        logic signed [lav_pkg::DIR_W-1:0] lx;
        logic signed [lav_pkg::POS_W-1:0] pz;
        logic signed [lav_pkg::POS_W-1:0] py;
        logic signed [lav_pkg::POS_W-1:0] px;
    } pose_t;

    // One view word: axes, translations and the degenerate flag
    typedef struct packed {
        logic [lav_pkg::DIR_W-1:0] rx, rz, ux, uy, uz, fx, fy, fz;
        logic [lav_pkg::POS_W-1:0] tr, tu, tf;
        logic                      degen;
    } view_t;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [lav_pkg::IN_W-1:0]  s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [lav_pkg::OUT_W-1:0] m_tdata;
    logic [0:0]                m_tuser;

    pose_t pose_q[$];
    view_t view_q[$];
    pose_t cur_pose;
    int    mismatches;
    int    views_checked;
    int    degen_seen;
    int    send_gap;
    int    stall_left;
    bit    send_burst;
    bit    recv_burst;
    bit    stim_done;
    bit    s_taken;

    look_at_view_matrix_core #(.DIR_FRAC_BITS(DIR_F)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    // Rounded unit component of v for a vector of squared length s
    function automatic longint unit_part(longint v, logic [63:0] s);
        logic [63:0]  mag;
        logic [63:0]  n;
        logic [63:0]  cand;
        logic [63:0]  k;
        logic [127:0] rhs;
        logic [127:0] lhs;
        int           b;
        mag = (v < 0) ? -v : v;
        rhs = {64'd0, mag * mag} << (2 * DIR_F + 2);
        n   = 0;
        for (b = DIR_F; b >= 0; b--)
        begin
            cand = n | (64'd1 << b);
            if (cand <= (64'd1 << DIR_F))
            begin
                k   = 2 * cand - 1;
                lhs = {64'd0, k * k} * {64'd0, s};
                if (lhs <= rhs)
                    n = cand;
            end
        end
        return (v < 0) ? -longint'(n) : longint'(n);
    endfunction

    // Negate, round to nearest with ties up, saturate to 32 bits
    function automatic logic [31:0] trans_term(longint t);
        longint r;
        r = (-t + (longint'(1) << (DIR_F - 1))) >>> DIR_F;
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    // Build the view word that one pose must produce
    function automatic view_t compute_view(pose_t p);
        view_t  v;
        longint px, py, pz, dx, dy, dz;
        longint cx, cy, cz, rx, rz, ux, uy, uz;
        longint sr, su;
        px = p.px; py = p.py; pz = p.pz;
        dx = p.lx; dy = p.ly; dz = p.lz;
        rx = 0; rz = 0; ux = 0; uy = 0; uz = 0;
        v = '0;
        v.degen = (dx == 0 && dz == 0);
        if (!v.degen)
        begin
            sr = dx * dx + dz * dz;
            cx = -(dy * dx);
            cy = dz * dz + dx * dx;
            cz = -(dy * dz);
            su = cx * cx + cy * cy + cz * cz;
            rx = unit_part(dz, sr);
            rz = unit_part(-dx, sr);
            ux = unit_part(cx, su);
            uy = unit_part(cy, su);
            uz = unit_part(cz, su);
            v.tr = trans_term(rx * px + rz * pz);
            v.tu = trans_term(ux * px + uy * py + uz * pz);
        end
        v.rx = rx[15:0]; v.rz = rz[15:0];
        v.ux = ux[15:0]; v.uy = uy[15:0]; v.uz = uz[15:0];
        v.fx = p.lx; v.fy = p.ly; v.fz = p.lz;
        v.tf = trans_term(dx * px + dy * py + dz * pz);
        return v;
    endfunction

    function automatic logic [15:0] rand_dir();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return 16'($urandom);
        if (sel < 8)
            return 16'($urandom_range(0, 32768) - 16384);
        if (sel == 8)
            return 16'd0;
        return ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
    endfunction

    function automatic logic [31:0] rand_pos();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return $urandom;
        if (sel < 8)
            return 32'($urandom_range(0, 2000000) - 1000000);
        if (sel == 8)
            return 32'h7FFF_FFFF;
        return 32'h8000_0000;
    endfunction

    function automatic void add_pose(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                     logic [15:0] a, logic [15:0] b, logic [15:0] c);
        pose_t p;
        p.px = x; p.py = y; p.pz = z;
        p.lx = a; p.ly = b; p.lz = c;
        pose_q.push_back(p);
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 12)
            return 0;
        if (sel < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Fill the pose queue: directed corners first, then random poses
    initial
    begin
        pose_t p;
        int    i;
        int    sel;
        add_pose(0, 0, 0, 0, 16384, 0);
        add_pose(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 0);
        add_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, -16'sd16384, 0);
        add_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16384, 0, 0);
        add_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, -16'sd16384, 0, 0);
        add_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 16384);
        add_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, -16'sd16384);
        add_pose(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 16'h8000, 16'h8000);
        add_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        add_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h7FFF, 16'h8000);
        add_pose(32'hFFFF_FFFF, 32'h1234_5678, 32'h0000_0001, 11585, 0, 11585);
        add_pose(32'h0000_0001, 32'hFFFF_FFFF, 32'h8765_4321, 9459, 9459, -16'sd9459);
        add_pose(32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 1, 16384, 0);
        add_pose(32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 0, -16'sd16384, 16'hFFFF);
        add_pose(32'h7FFF_FFFF, 0, 32'h8000_0000, 16'h0001, 16'h0000, 16'h0001);
        add_pose(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 16'h5555, 16'hAAAA, 16'h5555);
        add_pose(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA, 16'h5555, 16'hAAAA);
        add_pose(32'h0000_8000, 32'hFFFF_8000, 32'h0000_4000, 8192, 8192, 8192);
        add_pose(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 16'h8000, 0);
        for (i = 0; i < N_RANDOM; i++)
        begin
            p.px = rand_pos(); p.py = rand_pos(); p.pz = rand_pos();
            p.lx = rand_dir(); p.ly = rand_dir(); p.lz = rand_dir();
            sel = $urandom_range(0, 19);
            // Force a look with no horizontal part now and then
            if (sel == 0)
            begin
                p.lx = 0;
                p.lz = 0;
            end
            pose_q.push_back(p);
        end
        stim_done = 1'b1;
    end

    // Clock, reset and known input levels from time zero
    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        mismatches    = 0;
        views_checked = 0;
        degen_seen    = 0;
        send_gap      = 0;
        stall_left    = 0;
        send_burst    = 1'b0;
        recv_burst    = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Record the expected view for each accepted pose
    always @(posedge clk)
    begin
        s_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
            view_q.push_back(compute_view(cur_pose));
    end

    // Drive poses at the falling edge with random gaps
    always @(negedge clk)
    begin
        pose_t p;
        if (rst_n && (!s_tvalid || s_taken))
        begin
            if ($urandom_range(0, 99) == 0)
                send_burst <= ~send_burst;
            if (send_gap > 0 && !send_burst)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (pose_q.size() > 0)
            begin
                p         = pose_q.pop_front();
                cur_pose <= p;
                s_tdata  <= p;
                s_tvalid <= 1'b1;
                send_gap <= pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Stall the master side at random
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 99) == 0)
                recv_burst <= ~recv_burst;
            if (stall_left > 0 && !recv_burst)
            begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end
            else
            begin
                m_tready   <= 1'b1;
                stall_left <= pick_gap();
            end
        end
    end

    // Check each view word against the oldest expectation
    always @(posedge clk)
    begin
        view_t got;
        view_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.rx    = m_tdata[15:0];
            got.rz    = m_tdata[31:16];
            got.ux    = m_tdata[47:32];
            got.uy    = m_tdata[63:48];
            got.uz    = m_tdata[79:64];
            got.fx    = m_tdata[95:80];
            got.fy    = m_tdata[111:96];
            got.fz    = m_tdata[127:112];
            got.tr    = m_tdata[159:128];
            got.tu    = m_tdata[191:160];
            got.tf    = m_tdata[223:192];
            got.degen = m_tuser[0];
            if (view_q.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected view word %h", got);
            end
            else
            begin
                want = view_q.pop_front();
                views_checked = views_checked + 1;
                if (want.degen)
                    degen_seen = degen_seen + 1;
                if (got !== want)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                    begin
                        $display("view %0d mismatch", views_checked);
                        $display("  exp r=%h,%h u=%h,%h,%h f=%h,%h,%h t=%h,%h,%h dg=%b",
                                 want.rx, want.rz, want.ux, want.uy, want.uz,
                                 want.fx, want.fy, want.fz, want.tr, want.tu, want.tf,
                                 want.degen);
                        $display("  got r=%h,%h u=%h,%h,%h f=%h,%h,%h t=%h,%h,%h dg=%b",
                                 got.rx, got.rz, got.ux, got.uy, got.uz,
                                 got.fx, got.fy, got.fz, got.tr, got.tu, got.tf,
                                 got.degen);
                    end
                end
            end
        end
    end

    // Drain and report
    initial
    begin
        wait (stim_done && rst_n);
        @(posedge clk);
        while (pose_q.size() > 0 || s_tvalid || view_q.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        $display("checked %0d view words, %0d with a degenerate look", views_checked,
                 degen_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && view_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Give up after a generous time
    initial
    begin
        #2000000;
        $display("timeout, %0d view words still expected", view_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
